/* rtl/core/tne_pkg.sv */
// Shared types and constants for the tree node eccentricity core.
`timescale 1ns / 1ps
`default_nettype none
package tne_pkg;
  localparam int unsigned MaxNodes   = 1024;
  localparam int unsigned NodeBits   = 10;
  localparam int unsigned CountBits  = 11;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned DistBits   = 26;
  localparam int unsigned MaxEdges   = MaxNodes - 1;

  typedef logic [NodeBits-1:0]   node_t;
  typedef logic [DistBits-1:0]   dist_t;
  typedef logic [WeightBits-1:0] weight_t;
  typedef logic [CountBits-1:0]  count_t;

  typedef enum logic [1:0] {
    CmdClear   = 2'd0,
    CmdAddEdge = 2'd1,
    CmdCompute = 2'd2,
    CmdQuery   = 2'd3
  } cmd_e;

  localparam dist_t DistMax = {DistBits{1'b1}};

  // Saturating distance add.
  function automatic dist_t sat_add(dist_t a, weight_t w);
    logic [DistBits:0] s;
    s = {1'b0, a} + {{(DistBits + 1 - WeightBits){1'b0}}, w};
    sat_add = s[DistBits] ? DistMax : s[DistBits-1:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/core/tree_node_eccentricity_core.sv */
// Top level of the tree node eccentricity core: command decode, walk sequencer, memories.
//
// Usage: drive command_i, node_a_i, node_b_i and edge_weight_i with start high while
// busy is low; the command is transferred at that edge. Clear and add-edge commands
// finish at that edge and never raise busy. A query gives one result, via StQry1,
// StQry2 and the result register, shown for one cycle with result_valid_o; the
// receiver cannot stall it. Busy stays high through StQry1 and StQry2, so no new query
// is taken before the last is through (the answer memories have a registered read).
// Compute holds busy high while three breadth-first walks run. Each walk first clears
// its visited marks and distances, one entry a cycle over node_count entries, then for
// each node taken from the queue (StPop, StPopW) scans the whole edge store, checking
// both endpoints of each edge in turn over single read ports (StScan to StVisW).
// The node_count register is written through cfg_valid_i / cfg_ready_o; a write
// invalidates earlier answers. Reset clears the edge count, node count (to 1), and
// the answer-ready flag; memory contents are left as they are and need no clearing
// pass, since only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module tree_node_eccentricity_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [1:0]               command_i,
  input  wire logic [9:0]               node_a_i,
  input  wire logic [9:0]               node_b_i,
  input  wire logic [15:0]              edge_weight_i,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [10:0]              cfg_data_i,
  output logic                          result_valid_o,
  output logic [9:0]                    queried_node_o,
  output logic [25:0]                   farthest_distance_o,
  output logic                          status_o
);
  import tne_pkg::*;

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StClear  = 4'd1;
  localparam logic [3:0] StPop    = 4'd2;
  localparam logic [3:0] StPopW   = 4'd3;
  localparam logic [3:0] StScan   = 4'd4;
  localparam logic [3:0] StEdgeW  = 4'd5;
  localparam logic [3:0] StVisR   = 4'd6;
  localparam logic [3:0] StVisW   = 4'd7;
  localparam logic [3:0] StQry1   = 4'd8;
  localparam logic [3:0] StQry2   = 4'd9;
  localparam logic [3:0] StEnq2   = 4'd10;

  logic [3:0] st_q, st_d;
  count_t     ncount_q;
  logic [NodeBits-1:0] nedges_q;
  logic       ready_q;
  logic [1:0] walk_q;          // 0, 1, 2
  count_t     idx_q;           // clear index / edge index
  count_t     head_q, tail_q;
  node_t      start_q, best_q, u_q;
  dist_t      l_q, bestd_q;
  node_t      qnode_q;
  logic       side_q;          // which endpoint of the current edge

  // Edge memories.
  logic  e_we;
  node_t e_waddr, e_raddr, e_a_rd, e_b_rd;
  weight_t e_w_rd;
  // Visited marks.
  logic  v_we, v_wd, v_rd;
  node_t v_waddr, v_raddr;
  // Queue.
  logic  q_we;
  node_t q_waddr, q_raddr, qn_rd;
  dist_t qd_wd, qd_rd;
  node_t qn_wd;
  // Distance stores.
  logic  da_we, db_we;
  node_t d_waddr, d_raddr;
  dist_t d_wd, da_rd, db_rd;

  tne_ram #(.Depth(MaxNodes), .Width(NodeBits)) u_ea (.clk_i, .we_i(e_we),
    .waddr_i(e_waddr), .wdata_i(node_a_i), .raddr_i(e_raddr), .rdata_o(e_a_rd));
  tne_ram #(.Depth(MaxNodes), .Width(NodeBits)) u_eb (.clk_i, .we_i(e_we),
    .waddr_i(e_waddr), .wdata_i(node_b_i), .raddr_i(e_raddr), .rdata_o(e_b_rd));
  tne_ram #(.Depth(MaxNodes), .Width(WeightBits)) u_ew (.clk_i, .we_i(e_we),
    .waddr_i(e_waddr), .wdata_i(edge_weight_i), .raddr_i(e_raddr), .rdata_o(e_w_rd));
  tne_ram #(.Depth(MaxNodes), .Width(1)) u_vis (.clk_i, .we_i(v_we),
    .waddr_i(v_waddr), .wdata_i(v_wd), .raddr_i(v_raddr), .rdata_o(v_rd));
  tne_ram #(.Depth(MaxNodes), .Width(NodeBits)) u_qn (.clk_i, .we_i(q_we),
    .waddr_i(q_waddr), .wdata_i(qn_wd), .raddr_i(q_raddr), .rdata_o(qn_rd));
  tne_ram #(.Depth(MaxNodes), .Width(DistBits)) u_qd (.clk_i, .we_i(q_we),
    .waddr_i(q_waddr), .wdata_i(qd_wd), .raddr_i(q_raddr), .rdata_o(qd_rd));
  tne_ram #(.Depth(MaxNodes), .Width(DistBits)) u_da (.clk_i, .we_i(da_we),
    .waddr_i(d_waddr), .wdata_i(d_wd), .raddr_i(d_raddr), .rdata_o(da_rd));
  tne_ram #(.Depth(MaxNodes), .Width(DistBits)) u_db (.clk_i, .we_i(db_we),
    .waddr_i(d_waddr), .wdata_i(d_wd), .raddr_i(d_raddr), .rdata_o(db_rd));

  logic  go;
  count_t cfg_val;
  node_t cand;
  dist_t nd;
  logic  match_a, match_b, cand_hit;
  logic  clr_last;

  assign busy        = (st_q != StIdle);
  assign cfg_ready_o = (st_q == StIdle);
  assign go          = start && !busy;

  // Clamp the node count write.
  always_comb begin
    cfg_val = cfg_data_i;
    if (cfg_val == '0) cfg_val = count_t'(1);
    if (cfg_val > count_t'(MaxNodes)) cfg_val = count_t'(MaxNodes);
  end

  // Current edge matches; pick the far endpoint for the side being checked.
  assign match_a  = (e_a_rd == u_q);
  assign match_b  = (e_b_rd == u_q);
  assign cand     = side_q ? e_a_rd : e_b_rd;
  assign cand_hit = side_q ? match_b : match_a;
  assign nd       = sat_add(l_q, e_w_rd);
  assign clr_last = (idx_q + count_t'(1) >= ncount_q);

  // Memory port control.
  always_comb begin
    e_we    = go && (cmd_e'(command_i) == CmdAddEdge) && ({1'b0, node_a_i} < ncount_q)
              && ({1'b0, node_b_i} < ncount_q) && (nedges_q < NodeBits'(MaxEdges));
    e_waddr = nedges_q;
    e_raddr = idx_q[NodeBits-1:0];
    v_we    = 1'b0;
    v_waddr = idx_q[NodeBits-1:0];
    v_wd    = 1'b0;
    v_raddr = cand;
    q_we    = 1'b0;
    q_waddr = tail_q[NodeBits-1:0];
    qn_wd   = cand;
    qd_wd   = nd;
    q_raddr = head_q[NodeBits-1:0];
    da_we   = 1'b0;
    db_we   = 1'b0;
    d_waddr = u_q;
    d_wd    = l_q;
    d_raddr = qnode_q;
    unique case (st_q)
      StClear: begin
        v_we  = 1'b1;
        da_we = (walk_q != 2'd2);
        db_we = (walk_q == 2'd2);
        d_waddr = idx_q[NodeBits-1:0];
        d_wd  = '0;
      end
      StEnq2: begin
        // Mark and enqueue the start node.
        v_we = 1'b1; v_waddr = start_q; v_wd = 1'b1;
        q_we = 1'b1; q_waddr = '0; qn_wd = start_q; qd_wd = '0;
      end
      StPopW: begin
        // Store the distance of the entry just read from the queue.
        da_we = (walk_q != 2'd2);
        db_we = (walk_q == 2'd2);
        d_waddr = qn_rd;
        d_wd    = qd_rd;
      end
      StVisW: begin
        if (!v_rd && cand_hit && ({1'b0, cand} < ncount_q) && (tail_q < count_t'(MaxNodes)))
        begin
          v_we = 1'b1; v_waddr = cand; v_wd = 1'b1;
          q_we = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (go) begin
        if (cmd_e'(command_i) == CmdCompute) st_d = StClear;
        else if (cmd_e'(command_i) == CmdQuery) st_d = StQry1;
      end
      StClear: if (clr_last) st_d = StEnq2;
      StEnq2:  st_d = StPop;
      StPop: begin
        // Pop the next entry if any; when the walk is done, finish after the third, else seed the next one.
        if (head_q < tail_q) st_d = StPopW;
        else if (walk_q == 2'd2) st_d = StIdle;
        else st_d = StClear;
      end
      StPopW:  st_d = StScan;
      StScan:  st_d = (idx_q < count_t'(nedges_q)) ? StEdgeW : StPop;
      StEdgeW: st_d = StVisR;
      StVisR:  st_d = StVisW;
      StVisW:  st_d = side_q ? StScan : StVisR;
      StQry1:  st_d = StQry2;
      StQry2:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  // Control and walk registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      ncount_q <= count_t'(1);
      nedges_q <= '0;
      ready_q  <= 1'b0;
      walk_q   <= '0;
      idx_q    <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      side_q   <= 1'b0;
      start_q  <= '0;
      best_q   <= '0;
      bestd_q  <= '0;
      u_q      <= '0;
      l_q      <= '0;
      qnode_q  <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ncount_q <= cfg_val;
        ready_q  <= 1'b0;
      end
      if (e_we) nedges_q <= nedges_q + NodeBits'(1);
      if (go) begin
        qnode_q <= node_a_i;
        unique case (cmd_e'(command_i))
          CmdClear:   begin nedges_q <= '0; ready_q <= 1'b0; end
          CmdAddEdge: ready_q <= 1'b0;
          CmdCompute: begin walk_q <= 2'd0; start_q <= '0; idx_q <= '0; end
          CmdQuery:   ;
          default:    ;
        endcase
      end
      unique case (st_q)
        StClear: idx_q <= idx_q + count_t'(1);
        StEnq2: begin
          head_q <= '0; tail_q <= count_t'(1);
          best_q <= '0; bestd_q <= '0;
        end
        StPop: begin
          if (head_q >= tail_q) begin
            // Walk done: after the third walk the answers are ready, else the farthest node seeds the next walk.
            idx_q <= '0;
            if (walk_q == 2'd2) begin
              ready_q <= 1'b1;
            end else begin
              walk_q  <= walk_q + 2'd1;
              start_q <= best_q;
            end
          end
        end
        StPopW: begin
          head_q <= head_q + count_t'(1);
          idx_q  <= '0;
          side_q <= 1'b0;
        end
        StScan: ;
        StEdgeW: ;
        StVisR: ;
        StVisW: begin
          if (q_we) tail_q <= tail_q + count_t'(1);
          if (side_q) idx_q <= idx_q + count_t'(1);
          side_q <= !side_q;
        end
        default: ;
      endcase
      // Latch the popped entry from the registered queue read data in StPopW.
      if (st_q == StPopW) begin
        u_q <= qn_rd;
        l_q <= qd_rd;
        if (bestd_q < qd_rd) begin
          best_q  <= qn_rd;
          bestd_q <= qd_rd;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= (st_q == StQry2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StQry2) begin
      queried_node_o <= qnode_q;
      if (ready_q && ({1'b0, qnode_q} < ncount_q)) begin
        farthest_distance_o <= (da_rd > db_rd) ? da_rd : db_rd;
        status_o <= 1'b0;
      end else begin
        farthest_distance_o <= '0;
        status_o <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/tne_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module tne_ram #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 10
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write and read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

/* rtl/core/tne_checker.sv */
// Port-level checker for the tree node eccentricity core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module tne_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  command_i,
  input wire logic        cfg_ready_o,
  input wire logic        result_valid_o,
  input wire logic [25:0] farthest_distance_o,
  input wire logic        status_o
);
  import tne_pkg::*;

  // A query transfer always yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && command_i == CmdQuery |-> ##3 result_valid_o)
    else $error("query result missing");

  // Error results carry zero distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o |-> farthest_distance_o == '0)
    else $error("error result with distance");

  // Configuration is taken only when idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o == !busy)
    else $error("config ready while busy");

  // Results never come on consecutive cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back to back results");
endmodule

bind tree_node_eccentricity_core tne_checker u_tne_checker (.*);
`default_nettype wire

/* tb/tb.sv */
// Testbench for tree_node_eccentricity_core: random trees, computes and queries with a checker.
`timescale 1ns / 1ps
module tb;
  import tne_pkg::*;

  localparam int IdleLimit = 1000000;

  typedef struct {
    cmd_e    cmd;
    node_t   na;
    node_t   nb;
    weight_t w;
  } cmd_item_t;

  typedef struct {
    node_t node;
    dist_t dist_val;
    logic  st;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] command_i = '0;
  logic [9:0] node_a_i = '0;
  logic [9:0] node_b_i = '0;
  logic [15:0] edge_weight_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [10:0] cfg_data_i = '0;
  logic result_valid_o;
  logic [9:0] queried_node_o;
  logic [25:0] farthest_distance_o;
  logic status_o;

  tree_node_eccentricity_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .command_i(command_i), .node_a_i(node_a_i), .node_b_i(node_b_i),
    .edge_weight_i(edge_weight_i), .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i), .result_valid_o(result_valid_o),
    .queried_node_o(queried_node_o), .farthest_distance_o(farthest_distance_o),
    .status_o(status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow state of the core
  int      nodes_used;
  int      edge_cnt;
  int      e_first [MaxEdges];
  int      e_second[MaxEdges];
  int      e_len   [MaxEdges];
  int      dist_a  [MaxNodes];
  int      dist_b  [MaxNodes];
  bit      seen    [MaxNodes];
  int      wq_node [MaxNodes];
  int      wq_dist [MaxNodes];
  int      wq_tail;
  bit      answers_valid;

  cmd_item_t pending_cmds[$];
  answer_t   answers_due[$];
  int        err_cnt, accepted_cnt, query_cnt, compute_cnt, cfg_cnt;
  logic      xfer_seen;
  bit        in_xfer;
  int        gap_left;
  bit        stim_done;

  function automatic void enqueue_node(int v, longint d);
    if (v >= nodes_used || seen[v] || wq_tail >= MaxNodes) return;
    seen[v] = 1'b1;
    wq_node[wq_tail] = v;
    wq_dist[wq_tail] = (d > longint'(DistMax)) ? int'(DistMax) : int'(d);
    wq_tail++;
  endfunction

  // Breadth-first walk from src; distances land in dist_b when to_b is set
  function automatic int walk_farthest(int src, bit to_b);
    int head, best, best_d, u, l;
    longint nd;
    head = 0;
    best = 0;
    best_d = 0;
    for (int i = 0; i < MaxNodes; i++) begin
      seen[i] = 1'b0;
      if (to_b) dist_b[i] = 0;
      else dist_a[i] = 0;
    end
    wq_tail = 0;
    enqueue_node(src, 0);
    while (head < wq_tail) begin
      u = wq_node[head];
      l = wq_dist[head];
      head++;
      if (to_b) dist_b[u] = l;
      else dist_a[u] = l;
      if (best_d < l) begin
        best = u;
        best_d = l;
      end
      for (int e = 0; e < edge_cnt; e++) begin
        nd = longint'(l) + e_len[e];
        if (e_first[e] == u) enqueue_node(e_second[e], nd);
        if (e_second[e] == u) enqueue_node(e_first[e], nd);
      end
    end
    return best;
  endfunction

  // Advance the shadow state by one transferred command
  function automatic void predict_cmd(cmd_item_t it);
    answer_t ans;
    int a, b, da, db;
    case (it.cmd)
      CmdClear: begin
        edge_cnt = 0;
        answers_valid = 1'b0;
      end
      CmdAddEdge: begin
        answers_valid = 1'b0;
        if (it.na < nodes_used && it.nb < nodes_used && edge_cnt < MaxEdges) begin
          e_first[edge_cnt] = it.na;
          e_second[edge_cnt] = it.nb;
          e_len[edge_cnt] = it.w;
          edge_cnt++;
        end
      end
      CmdCompute: begin
        a = walk_farthest(0, 1'b0);
        b = walk_farthest(a, 1'b0);
        void'(walk_farthest(b, 1'b1));
        answers_valid = 1'b1;
        compute_cnt++;
      end
      default: begin
        ans.node = it.na;
        if (answers_valid && it.na < nodes_used) begin
          da = dist_a[it.na];
          db = dist_b[it.na];
          ans.dist_val = dist_t'((da > db) ? da : db);
          ans.st = 1'b0;
        end else begin
          ans.dist_val = '0;
          ans.st = 1'b1;
        end
        answers_due = {answers_due, ans};
        query_cnt++;
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Check results and predict on every command transfer
  always @(posedge clk_i) begin
    answer_t want;
    cmd_item_t it;
    in_xfer = rst_ni && start && !busy;
    xfer_seen <= (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o);
    if (rst_ni && result_valid_o) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result, node", queried_node_o, -1);
      end else begin
        want = answers_due.pop_front();
        if (queried_node_o !== want.node) report_mismatch("queried_node", queried_node_o, want.node);
        if (farthest_distance_o !== want.dist_val)
          report_mismatch("farthest_distance", farthest_distance_o, want.dist_val);
        if (status_o !== want.st) report_mismatch("status", status_o, want.st);
      end
    end
    if (rst_ni && start && !busy) begin
      it.cmd = cmd_e'(command_i);
      it.na = node_a_i;
      it.nb = node_b_i;
      it.w = edge_weight_i;
      predict_cmd(it);
      accepted_cnt++;
    end
  end

  // Watchdog on cycles without any transfer
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if (xfer_seen || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("tree_node_eccentricity_core verification failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive commands from the pending queue; hold each until its transfer
  always @(negedge clk_i) begin
    cmd_item_t nxt;
    if (start && !in_xfer) begin
      // hold
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      nxt = pending_cmds.pop_front();
      command_i <= nxt.cmd;
      node_a_i <= nxt.na;
      node_b_i <= nxt.nb;
      edge_weight_i <= nxt.w;
      start <= 1'b1;
      gap_left <= pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  task automatic push_cmd(cmd_e c, int a, int b, int w);
    cmd_item_t it;
    it.cmd = c;
    it.na = node_t'(a);
    it.nb = node_t'(b);
    it.w = weight_t'(w);
    pending_cmds = {pending_cmds, it};
  endtask

  // Wait until the core is idle and every answer has arrived
  task automatic drain();
    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || start || busy || answers_due.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_count(int v);
    drain();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= count_t'(v);
    do @(posedge clk_i);
    while (!cfg_ready_o);
    nodes_used = (v & 11'h7FF);
    if (nodes_used == 0) nodes_used = 1;
    if (nodes_used > MaxNodes) nodes_used = MaxNodes;
    answers_valid = 1'b0;
    cfg_cnt++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Load a random tree over n nodes, edges in shuffled order
  task automatic load_tree(int n, int wmax);
    int ea[$], eb[$];
    int j, p, t;
    for (int i = 1; i < n; i++) begin
      p = $urandom_range(0, i - 1);
      if ($urandom_range(0, 1)) begin
        ea = {ea, i};
        eb = {eb, p};
      end else begin
        ea = {ea, p};
        eb = {eb, i};
      end
    end
    for (int i = ea.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = ea[i]; ea[i] = ea[j]; ea[j] = t;
      t = eb[i]; eb[i] = eb[j]; eb[j] = t;
    end
    foreach (ea[k]) push_cmd(CmdAddEdge, ea[k], eb[k], $urandom_range(0, wmax));
  endtask

  task automatic random_queries(int n, int cnt);
    for (int k = 0; k < cnt; k++) begin
      if ($urandom_range(0, 9) < 8) push_cmd(CmdQuery, $urandom_range(0, n - 1),
                                              $urandom, $urandom);
      else push_cmd(CmdQuery, $urandom_range(0, 1023), $urandom, $urandom);
    end
  endtask

  initial begin
    int n, r;
    nodes_used = 1;
    edge_cnt = 0;
    answers_valid = 1'b0;
    gap_left = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: queries before compute, single node default, range clamps
    push_cmd(CmdQuery, 0, 0, 0);
    push_cmd(CmdCompute, 0, 0, 0);
    push_cmd(CmdQuery, 0, 1023, 65535);
    push_cmd(CmdQuery, 1, 0, 0);
    push_cmd(CmdQuery, 1023, 0, 0);
    write_count(0);
    push_cmd(CmdAddEdge, 0, 1, 5);
    push_cmd(CmdCompute, 0, 0, 0);
    push_cmd(CmdQuery, 0, 0, 0);
    write_count(2047);
    push_cmd(CmdAddEdge, 1023, 0, 65535);
    push_cmd(CmdAddEdge, 0, 1023, 65535);
    push_cmd(CmdAddEdge, 1000, 1023, 1);
    push_cmd(CmdQuery, 1023, 0, 0);
    push_cmd(CmdCompute, 0, 0, 0);
    push_cmd(CmdQuery, 1023, 0, 0);
    push_cmd(CmdQuery, 1000, 0, 0);
    push_cmd(CmdQuery, 512, 0, 0);
    push_cmd(CmdClear, 0, 0, 0);
    push_cmd(CmdQuery, 1023, 0, 0);
    write_count(1024);
    push_cmd(CmdQuery, 0, 0, 0);
    write_count(3);
    push_cmd(CmdAddEdge, 0, 3, 7);
    push_cmd(CmdAddEdge, 0, 1, 9);
    push_cmd(CmdAddEdge, 1, 2, 9);
    push_cmd(CmdCompute, 0, 0, 0);
    push_cmd(CmdQuery, 2, 0, 0);
    push_cmd(CmdQuery, 3, 0, 0);

    // Load many parallel edges and loops on a small node set
    write_count(4);
    push_cmd(CmdClear, 0, 0, 0);
    for (int k = 0; k < 40; k++)
      push_cmd(CmdAddEdge, $urandom_range(0, 3), $urandom_range(0, 3), $urandom);
    push_cmd(CmdCompute, 0, 0, 0);
    random_queries(4, 6);

    // Random phases: mostly proper trees, some broken graphs and noise
    while (accepted_cnt + pending_cmds.size() < 850) begin
      r = $urandom_range(0, 99);
      if (r < 70) n = $urandom_range(2, 24);
      else if (r < 90) n = $urandom_range(1, 64);
      else if (r < 95) n = 1;
      else n = 1024;
      write_count(($urandom_range(0, 19) == 0) ? n + 1024 * $urandom_range(1, 0) : n);
      push_cmd(CmdClear, 0, 0, 0);
      if (n == 1024) begin
        for (int k = 0; k < 6; k++)
          push_cmd(CmdAddEdge, $urandom_range(1000, 1023), $urandom_range(1000, 1023),
                   $urandom);
        push_cmd(CmdAddEdge, 0, 1023, $urandom);
      end else if ($urandom_range(0, 9) < 7) begin
        load_tree(n, ($urandom_range(0, 3) == 0) ? 65535 : 255);
      end else begin
        for (int k = 0; k < $urandom_range(0, 2 * n); k++)
          push_cmd(CmdAddEdge, $urandom_range(0, n), $urandom_range(0, n), $urandom);
        push_cmd(CmdAddEdge, $urandom, $urandom, $urandom);
      end
      if ($urandom_range(0, 9) == 0) push_cmd(CmdQuery, 0, 0, 0);
      push_cmd(CmdCompute, 0, 0, 0);
      random_queries((n > 1023) ? 1024 : n, $urandom_range(3, 12));
      r = $urandom_range(0, 9);
      if (r == 0) begin
        push_cmd(CmdAddEdge, $urandom, $urandom, $urandom);
        random_queries(n, 2);
      end else if (r == 1) begin
        push_cmd(CmdClear, $urandom, $urandom, $urandom);
        random_queries(n, 2);
      end else if (r == 2) begin
        for (int k = 0; k < 6; k++)
          push_cmd(cmd_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
        push_cmd(CmdCompute, 0, 0, 0);
        random_queries(n, 3);
      end
      drain();
    end

    drain();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d commands: %0d computes, %0d queries, %0d node count writes.",
             accepted_cnt, compute_cnt, query_cnt, cfg_cnt);
    if (err_cnt == 0 && answers_due.size() == 0) begin
      $display("tree_node_eccentricity_core verification clean");
    end else begin
      $display("%0d mismatches, %0d answers missing", err_cnt, answers_due.size());
      $display("tree_node_eccentricity_core verification failed");
    end
    $finish;
  end
endmodule
